FILE: rtl/kdm_pkg.sv
// Package for the knob dimmer mode controller.
// Mode encoding, reset values, register indices and the step control struct.
// No dependencies.
package kdm_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 5;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_STEP   = 2'd2;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd3000;
  localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [7:0]  LEVEL_STEP_RST   = 8'd5;
  localparam logic [7:0]  LEVEL_MAX        = 8'd255;

  localparam int unsigned CH_OUT_W = 3;

  typedef enum logic [1:0] {
    MODE_HOME   = 2'd0,
    MODE_SELECT = 2'd1,
    MODE_EDIT   = 2'd2
  } mode_e;

  // Decisions for one poll, handed from the mode FSM to the level store.
  typedef struct packed {
    logic sel_step;
    logic sel_up;
    logic edit_step;
    logic edit_up;
    logic latch;
  } kdm_ctrl_t;

endpackage

FILE: rtl/kdm_mode_fsm.sv
// Mode FSM: mode, selected channel, button hold, timestamps and knob position.
// Produces next-state values and the per-poll control struct. Uses kdm_pkg.
module kdm_mode_fsm #(
  parameter int unsigned NUM_CHANNELS = kdm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  advance_i,
  input  logic                                  button_down_i,
  input  logic signed [15:0]                    encoder_count_i,
  input  logic [31:0]                           now_ms_i,
  input  logic [15:0]                           idle_timeout_ms_i,
  input  logic [15:0]                           long_press_ms_i,
  output kdm_pkg::mode_e                        mode_d_o,
  output logic [$clog2(NUM_CHANNELS+1)-1:0]     channel_q_o,
  output logic [$clog2(NUM_CHANNELS+1)-1:0]     channel_d_o,
  output kdm_pkg::kdm_ctrl_t                    ctrl_o
);
  import kdm_pkg::*;

  localparam int unsigned CH_W = $clog2(NUM_CHANNELS + 1);
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS);
  localparam logic [CH_W-1:0] CH_FIRST = CH_W'(1);

  mode_e              mode_q, mode_d, mode_mid;
  logic [CH_W-1:0]    channel_q, channel_d;
  logic               held_q;
  logic [31:0]        press_q, press_d;
  logic [31:0]        act_q, act_d;
  logic signed [15:0] last_half_q, last_half_d;

  logic               timeout, press, release_edge, long_held, moved, knob_up;
  logic signed [16:0] half_sum;
  logic signed [15:0] half;
  kdm_ctrl_t          ctrl;

  // Halve toward zero: add one to negatives before the arithmetic shift.
  assign half_sum = {encoder_count_i[15], encoder_count_i}
                  + {16'b0, encoder_count_i[15]};
  assign half     = half_sum[16:1];

  assign timeout      = (mode_q != MODE_HOME)
                      && ((now_ms_i - act_q) > {16'b0, idle_timeout_ms_i});
  assign press        = button_down_i && !held_q;
  assign release_edge = !button_down_i && held_q;
  assign long_held    = (now_ms_i - press_q) > {16'b0, long_press_ms_i};
  assign moved        = half != last_half_q;
  assign knob_up      = half > last_half_q;

  // Next state
  always_comb begin
    mode_mid = timeout ? MODE_HOME : mode_q;
    mode_d   = mode_mid;
    if (release_edge) begin
      unique case (mode_mid)
        MODE_EDIT:   mode_d = MODE_HOME;
        MODE_SELECT: mode_d = MODE_EDIT;
        MODE_HOME:   mode_d = long_held ? MODE_SELECT : MODE_HOME;
        default:     mode_d = MODE_HOME;
      endcase
    end
  end

  // Outputs of the FSM for this poll
  always_comb begin
    ctrl.sel_step  = (mode_d == MODE_SELECT) && moved;
    ctrl.sel_up    = knob_up;
    ctrl.edit_step = (mode_d == MODE_EDIT) && moved;
    ctrl.edit_up   = knob_up;
    ctrl.latch     = timeout || (release_edge && (mode_mid == MODE_EDIT)) || ctrl.edit_step;
  end

  always_comb begin
    channel_d = channel_q;
    if (ctrl.sel_step) begin
      if (knob_up) begin
        channel_d = (channel_q >= CH_LAST) ? CH_FIRST : channel_q + CH_FIRST;
      end else begin
        channel_d = (channel_q <= CH_FIRST) ? CH_LAST : channel_q - CH_FIRST;
      end
    end
    press_d = press ? now_ms_i : press_q;
    act_d   = act_q;
    if (press || (release_edge && (mode_mid == MODE_HOME) && long_held)
        || ctrl.sel_step || ctrl.edit_step) begin
      act_d = now_ms_i;
    end
    last_half_d = (ctrl.sel_step || ctrl.edit_step) ? half : last_half_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_HOME;
      channel_q   <= CH_FIRST;
      held_q      <= 1'b0;
      press_q     <= '0;
      act_q       <= '0;
      last_half_q <= '0;
    end else if (advance_i) begin
      mode_q      <= mode_d;
      channel_q   <= channel_d;
      held_q      <= button_down_i;
      press_q     <= press_d;
      act_q       <= act_d;
      last_half_q <= last_half_d;
    end
  end

  assign mode_d_o    = mode_d;
  assign channel_q_o = channel_q;
  assign channel_d_o = channel_d;
  assign ctrl_o      = ctrl;

endmodule

FILE: rtl/kdm_level_store.sv
// Per-channel intensity table, selected-level register and lit outputs.
// Applies clamped level steps and latches the lit channel. Uses kdm_pkg.
module kdm_level_store #(
  parameter int unsigned NUM_CHANNELS = kdm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              advance_i,
  input  kdm_pkg::kdm_ctrl_t                ctrl_i,
  input  logic [$clog2(NUM_CHANNELS+1)-1:0] channel_q_i,
  input  logic [$clog2(NUM_CHANNELS+1)-1:0] channel_d_i,
  input  logic [7:0]                        level_step_i,
  output logic [7:0]                        sel_level_d_o,
  output logic [$clog2(NUM_CHANNELS+1)-1:0] lit_channel_d_o,
  output logic [7:0]                        lit_level_d_o
);
  import kdm_pkg::*;

  localparam int unsigned CH_W  = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [7:0]       level_q [NUM_CHANNELS];
  logic [7:0]       sel_level_q, sel_level_d;
  logic [CH_W-1:0]  lit_ch_q, lit_ch_d;
  logic [7:0]       lit_lv_q, lit_lv_d;
  logic [CH_W-1:0]  wr_off, rd_off;
  logic [IDX_W-1:0] wr_idx, rd_idx;
  logic [8:0]       up_sum;
  logic [7:0]       new_lv;

  assign wr_off = channel_q_i - CH_W'(1);
  assign rd_off = channel_d_i - CH_W'(1);
  assign wr_idx = wr_off[IDX_W-1:0];
  assign rd_idx = rd_off[IDX_W-1:0];

  assign up_sum = {1'b0, sel_level_q} + {1'b0, level_step_i};

  always_comb begin
    if (ctrl_i.edit_up) begin
      new_lv = up_sum[8] ? LEVEL_MAX : up_sum[7:0];
    end else begin
      new_lv = (sel_level_q < level_step_i) ? 8'd0 : sel_level_q - level_step_i;
    end
    if (ctrl_i.edit_step) begin
      sel_level_d = new_lv;
    end else if (ctrl_i.sel_step) begin
      sel_level_d = level_q[rd_idx];
    end else begin
      sel_level_d = sel_level_q;
    end
    // a latch always takes the channel as it stood before this item's channel step
    lit_ch_d = ctrl_i.latch ? channel_q_i : lit_ch_q;
    lit_lv_d = ctrl_i.latch ? (ctrl_i.edit_step ? new_lv : sel_level_q) : lit_lv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
        level_q[i] <= LEVEL_MAX;
      end
      sel_level_q <= LEVEL_MAX;
      lit_ch_q    <= CH_W'(1);
      lit_lv_q    <= LEVEL_MAX;
    end else if (advance_i) begin
      if (ctrl_i.edit_step) begin
        level_q[wr_idx] <= new_lv;
      end
      sel_level_q <= sel_level_d;
      lit_ch_q    <= lit_ch_d;
      lit_lv_q    <= lit_lv_d;
    end
  end

  assign sel_level_d_o   = sel_level_d;
  assign lit_channel_d_o = lit_ch_d;
  assign lit_level_d_o   = lit_lv_d;

endmodule

FILE: rtl/knob_dimmer_mode_controller.sv
// Top level of the knob dimmer mode controller.
// Input register, config registers and result register; uses kdm_pkg,
// kdm_mode_fsm and kdm_level_store.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   poll in  | in_valid_i / in_ready_o | button_down_i, encoder_count_i, now_ms_i
//   result   | out_valid_o/out_ready_i | mode_o, selected_channel_o, selected_level_o,
//            |                         | lit_channel_o, lit_level_o
//   config   | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// Each item is held in the input register and then evaluated into the result
// register; one item per cycle while the result is not stalled.
// The state update is a single combinational pass from input register to
// result register. Reset is asynchronous; levels come up at 255.
// A stalled result holds the input register; in_ready_o drops only then.
module knob_dimmer_mode_controller #(
  parameter int unsigned NUM_CHANNELS = kdm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [kdm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [kdm_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 button_down_i,
  input  logic signed [15:0]                   encoder_count_i,
  input  logic [31:0]                          now_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           mode_o,
  output logic [2:0]                           selected_channel_o,
  output logic [7:0]                           selected_level_o,
  output logic [2:0]                           lit_channel_o,
  output logic [7:0]                           lit_level_o
);
  import kdm_pkg::*;

  localparam int unsigned CH_W = $clog2(NUM_CHANNELS + 1);

  logic [15:0]        idle_timeout_q, long_press_q;
  logic [7:0]         level_step_q;

  logic               in_valid_q;
  logic               button_q;
  logic signed [15:0] count_q;
  logic [31:0]        now_q;

  logic               out_valid_q;
  logic [1:0]         mode_out_q;
  logic [2:0]         sel_ch_out_q, lit_ch_out_q;
  logic [7:0]         sel_lv_out_q, lit_lv_out_q;

  logic               advance;
  mode_e              mode_d;
  logic [CH_W-1:0]    channel_q, channel_d, lit_ch_d;
  logic [7:0]         sel_level_d, lit_lv_d;
  kdm_ctrl_t          ctrl;
  logic [CH_W+2:0]    sel_ch_ext, lit_ch_ext;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_timeout_q <= IDLE_TIMEOUT_RST;
      long_press_q   <= LONG_PRESS_RST;
      level_step_q   <= LEVEL_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_wdata_i;
        CFG_LONG_PRESS:   long_press_q   <= cfg_wdata_i;
        CFG_LEVEL_STEP:   level_step_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      button_q <= button_down_i;
      count_q  <= encoder_count_i;
      now_q    <= now_ms_i;
    end
  end

  kdm_mode_fsm #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_mode_fsm (
    .clk_i,
    .rst_ni,
    .advance_i         (advance),
    .button_down_i     (button_q),
    .encoder_count_i   (count_q),
    .now_ms_i          (now_q),
    .idle_timeout_ms_i (idle_timeout_q),
    .long_press_ms_i   (long_press_q),
    .mode_d_o          (mode_d),
    .channel_q_o       (channel_q),
    .channel_d_o       (channel_d),
    .ctrl_o            (ctrl)
  );

  kdm_level_store #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_level_store (
    .clk_i,
    .rst_ni,
    .advance_i       (advance),
    .ctrl_i          (ctrl),
    .channel_q_i     (channel_q),
    .channel_d_i     (channel_d),
    .level_step_i    (level_step_q),
    .sel_level_d_o   (sel_level_d),
    .lit_channel_d_o (lit_ch_d),
    .lit_level_d_o   (lit_lv_d)
  );

  // channel numbers are shown in three bits
  assign sel_ch_ext = {3'b000, channel_d};
  assign lit_ch_ext = {3'b000, lit_ch_d};

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mode_out_q   <= mode_d;
      sel_ch_out_q <= sel_ch_ext[CH_OUT_W-1:0];
      sel_lv_out_q <= sel_level_d;
      lit_ch_out_q <= lit_ch_ext[CH_OUT_W-1:0];
      lit_lv_out_q <= lit_lv_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign mode_o             = mode_out_q;
  assign selected_channel_o = sel_ch_out_q;
  assign selected_level_o   = sel_lv_out_q;
  assign lit_channel_o      = lit_ch_out_q;
  assign lit_level_o        = lit_lv_out_q;

endmodule

FILE: rtl/kdm_checker.sv
// Port-level checks for knob_dimmer_mode_controller, bound to the top level.
// Uses kdm_pkg for the mode codes.
module kdm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] mode_o,
  input logic [2:0] selected_channel_o,
  input logic [2:0] lit_channel_o,
  input logic [7:0] selected_level_o
);
  import kdm_pkg::*;

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(selected_level_o)
      && $stable(mode_o))
    else $error("result changed while stalled");

  // an empty result register never holds back the input side
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // every fresh result follows an item accepted through the input register
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without an accepted item");

  a_legal_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mode_o == MODE_HOME || mode_o == MODE_SELECT || mode_o == MODE_EDIT)
      && selected_channel_o != 3'd0 && lit_channel_o != 3'd0)
    else $error("illegal mode or channel zero on result");

endmodule

bind knob_dimmer_mode_controller kdm_checker u_kdm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .mode_o             (mode_o),
  .selected_channel_o (selected_channel_o),
  .lit_channel_o      (lit_channel_o),
  .selected_level_o   (selected_level_o)
);
